FILE: src/arp_cache_and_responder_defines.svh
// assertion macros shared by the arp engine
`ifndef ARP_CACHE_AND_RESPONDER_DEFINES_SVH
`define ARP_CACHE_AND_RESPONDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ARPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during reset
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: src/arpc_pkg.sv
package arpc_pkg;

  // default number of cache cells
  localparam int unsigned CACHE_DEPTH_DEF = 16;

  // input operation codes
  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // arp protocol constants
  localparam logic [47:0] ARP_HDR_IPV4   = 48'h000108000604;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
  localparam logic [1:0]  FRM_OP_REQUEST = 2'd1;
  localparam logic [1:0]  FRM_OP_REPLY   = 2'd2;
  localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

  // result status codes
  localparam logic [3:0] STS_OK       = 4'd0;
  localparam logic [3:0] STS_BAD_HDR  = 4'd1;
  localparam logic [3:0] STS_OWN      = 4'd2;
  localparam logic [3:0] STS_MISMATCH = 4'd3;
  localparam logic [3:0] STS_NOT_OURS = 4'd4;
  localparam logic [3:0] STS_UNASKED  = 4'd5;
  localparam logic [3:0] STS_LOCAL    = 4'd6;
  localparam logic [3:0] STS_HIT      = 4'd7;
  localparam logic [3:0] STS_SENT     = 4'd8;
  localparam logic [3:0] STS_RESOLVED = 4'd9;
  localparam logic [3:0] STS_RETRY    = 4'd10;
  localparam logic [3:0] STS_FAILED   = 4'd11;
  localparam logic [3:0] STS_BUSY     = 4'd12;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_TTL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_CNT  = 3'd4;

  // configuration reset values
  localparam logic [15:0] TTL_RST        = 16'd60;
  localparam logic [15:0] RETRY_INTV_RST = 16'd1;
  localparam logic [3:0]  RETRY_CNT_RST  = 4'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] hdr_fixed;
    logic [15:0] arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] link_src_mac;
    logic [31:0] query_ip;
  } arpc_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        send_frame;
    logic [1:0]  frame_opcode;
    logic [47:0] frame_dest_mac;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;
    logic        resolve_done;
    logic        resolve_ok;
    logic [47:0] resolved_mac;
  } arpc_out_t;

  // one cache entry as it travels along the chain
  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] expiry;
  } arpc_entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_all;
    logic shift_match;
    logic load;
  } arpc_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PURGE,
    ST_REMOVE,
    ST_EVICT,
    ST_APPEND,
    ST_LOOKUP,
    ST_TICK
  } arpc_state_t;

endpackage

FILE: src/arpc_cell.sv
module arpc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  arpc_pkg::arpc_ctl_t   ctl,
  input  arpc_pkg::arpc_entry_t nbr_i,
  input  arpc_pkg::arpc_entry_t ld_i,
  input  logic [31:0]           key,
  input  logic                  prev_valid,
  input  logic                  prev_match,
  input  logic [47:0]           prev_mac,
  output arpc_pkg::arpc_entry_t ent_o,
  output logic                  match_o,
  output logic [47:0]           mac_o
);

  logic        valid_r, valid_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic        own_match;
  logic        shift;
  logic        load;

  // match chain: first matching cell from the head wins
  always_comb begin
    own_match = valid_r && (ip_r == key);
    match_o   = prev_match || own_match;
    mac_o     = (!prev_match && own_match) ? mac_r : prev_mac;
  end

  // shift from the right neighbor, or take the new entry at the first free cell
  always_comb begin
    shift     = ctl.shift_all || (ctl.shift_match && match_o);
    load      = ctl.load && !valid_r && prev_valid;
    valid_nxt = valid_r;
    ip_nxt    = ip_r;
    mac_nxt   = mac_r;
    exp_nxt   = exp_r;
    if (shift) begin
      valid_nxt = nbr_i.valid;
      ip_nxt    = nbr_i.ip;
      mac_nxt   = nbr_i.mac;
      exp_nxt   = nbr_i.expiry;
    end else if (load) begin
      valid_nxt = 1'b1;
      ip_nxt    = ld_i.ip;
      mac_nxt   = ld_i.mac;
      exp_nxt   = ld_i.expiry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r  <= ip_nxt;
    mac_r <= mac_nxt;
    exp_r <= exp_nxt;
  end

  assign ent_o = '{valid: valid_r, ip: ip_r, mac: mac_r, expiry: exp_r};

endmodule

FILE: src/arp_cache_and_responder.sv
// channel   ports                              transaction when
// input     start, busy, in_item               start high and busy low at clk
// result    out_valid, out_result              out_valid high, one cycle, no stall
// config    cfg_we, cfg_index, cfg_wdata       cfg_we high at clk
//
// an item runs in the control sequencer over a chain of cache cells, head = oldest.
// bad frames, local resolves and unknown ops are answered straight from the decode state.
// resolve runs purge then lookup, tick runs purge then tick, accepted frames run purge,
// remove, evict and append; purge drops expired head entries, one chain shift per cycle.
// synchronous active-low reset empties the cache and clears the resolver.
// the result strobe rises in the same cycle busy falls; results cannot be held off.
`include "arp_cache_and_responder_defines.svh"

module arp_cache_and_responder #(
  parameter int unsigned CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  arpc_pkg::arpc_in_t                in_item,
  output logic                              out_valid,
  output arpc_pkg::arpc_out_t               out_result,
  input  logic                              cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [47:0]                       cfg_wdata
);

  arpc_pkg::arpc_state_t state_r, state_nxt;
  arpc_pkg::arpc_in_t    item_r, item_nxt;
  arpc_pkg::arpc_out_t   out_r, out_nxt, res;
  logic                  out_valid_r, out_valid_nxt;
  logic                  emit;
  logic [31:0]           now_r, now_nxt;
  logic [31:0]           pending_ip_r, pending_ip_nxt;
  logic                  waiting_r, waiting_nxt;
  logic [3:0]            tries_r, tries_nxt;
  logic [15:0]           timer_r, timer_nxt;

  logic [31:0]           local_ip_r;
  logic [47:0]           local_mac_r;
  logic [15:0]           ttl_r;
  logic [15:0]           intv_r;
  logic [3:0]            rcnt_r;
  logic [15:0]           intv_eff;
  logic [3:0]            rcnt_eff;

  arpc_pkg::arpc_ctl_t   ctl;
  arpc_pkg::arpc_entry_t ld_ent;
  arpc_pkg::arpc_entry_t ent [CACHE_DEPTH];
  logic                  match_c [CACHE_DEPTH];
  logic [47:0]           mac_c [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] ent_valid;
  logic [31:0]           key;
  logic [31:0]           head_d;
  logic                  head_dead;
  logic                  hit;
  logic [47:0]           hit_mac;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r  <= '0;
      local_mac_r <= '0;
      ttl_r       <= arpc_pkg::TTL_RST;
      intv_r      <= arpc_pkg::RETRY_INTV_RST;
      rcnt_r      <= arpc_pkg::RETRY_CNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arpc_pkg::CFG_LOCAL_IP:   local_ip_r  <= cfg_wdata[31:0];
        arpc_pkg::CFG_LOCAL_MAC:  local_mac_r <= cfg_wdata;
        arpc_pkg::CFG_CACHE_TTL:  ttl_r       <= cfg_wdata[15:0];
        arpc_pkg::CFG_RETRY_INTV: intv_r      <= cfg_wdata[15:0];
        arpc_pkg::CFG_RETRY_CNT:  rcnt_r      <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // zero interval or count act as one
  assign intv_eff = (intv_r == '0) ? 16'd1 : intv_r;
  assign rcnt_eff = (rcnt_r == '0) ? 4'd1 : rcnt_r;

  // the cache chain
  assign key    = (item_r.op == arpc_pkg::OP_FRAME) ? item_r.sender_ip : item_r.query_ip;
  assign ld_ent = '{valid: 1'b1, ip: item_r.sender_ip, mac: item_r.sender_mac,
                    expiry: now_r + {16'd0, ttl_r}};

  for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
    arpc_pkg::arpc_entry_t nbr;
    logic                  pv;
    logic                  pm;
    logic [47:0]           pmac;

    if (g == CACHE_DEPTH - 1) begin : g_tail
      assign nbr = '{valid: 1'b0, ip: ld_ent.ip, mac: ld_ent.mac, expiry: ld_ent.expiry};
    end else begin : g_mid
      assign nbr = ent[g+1];
    end

    if (g == 0) begin : g_head
      assign pv   = 1'b1;
      assign pm   = 1'b0;
      assign pmac = '0;
    end else begin : g_body
      assign pv   = ent[g-1].valid;
      assign pm   = match_c[g-1];
      assign pmac = mac_c[g-1];
    end

    arpc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .nbr_i      (nbr),
      .ld_i       (ld_ent),
      .key        (key),
      .prev_valid (pv),
      .prev_match (pm),
      .prev_mac   (pmac),
      .ent_o      (ent[g]),
      .match_o    (match_c[g]),
      .mac_o      (mac_c[g])
    );

    assign ent_valid[g] = ent[g].valid;
  end

  assign hit     = match_c[CACHE_DEPTH-1];
  assign hit_mac = mac_c[CACHE_DEPTH-1];

  // head entry is alive while expiry - now lies in 1 .. 2^31-1
  assign head_d    = ent[0].expiry - now_r;
  assign head_dead = ent[0].valid && ((head_d == '0) || head_d[31]);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    out_nxt        = out_r;
    out_valid_nxt  = 1'b0;
    now_nxt        = now_r;
    pending_ip_nxt = pending_ip_r;
    waiting_nxt    = waiting_r;
    tries_nxt      = tries_r;
    timer_nxt      = timer_r;
    ctl            = '0;
    res            = '0;
    emit           = 1'b0;

    unique case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = arpc_pkg::ST_DECODE;
        end
      end

      arpc_pkg::ST_DECODE: begin
        case (item_r.op)
          arpc_pkg::OP_FRAME: begin
            if (item_r.hdr_fixed != arpc_pkg::ARP_HDR_IPV4) begin
              res.status = arpc_pkg::STS_BAD_HDR;
              emit       = 1'b1;
            end else if (item_r.sender_mac == local_mac_r) begin
              res.status = arpc_pkg::STS_OWN;
              emit       = 1'b1;
            end else if (item_r.sender_mac != item_r.link_src_mac) begin
              res.status = arpc_pkg::STS_MISMATCH;
              emit       = 1'b1;
            end else begin
              state_nxt = arpc_pkg::ST_PURGE;
            end
          end
          arpc_pkg::OP_RESOLVE: begin
            if (item_r.query_ip == local_ip_r) begin
              res.status       = arpc_pkg::STS_LOCAL;
              res.resolve_done = 1'b1;
              res.resolve_ok   = 1'b1;
              res.resolved_mac = local_mac_r;
              emit             = 1'b1;
            end else begin
              state_nxt = arpc_pkg::ST_PURGE;
            end
          end
          arpc_pkg::OP_TICK: begin
            now_nxt   = now_r + 32'd1;
            state_nxt = arpc_pkg::ST_PURGE;
          end
          default: begin
            res.status = arpc_pkg::STS_OK;
            emit       = 1'b1;
          end
        endcase
      end

      // drop expired entries from the head, one per cycle
      arpc_pkg::ST_PURGE: begin
        if (head_dead) begin
          ctl.shift_all = 1'b1;
        end else if (item_r.op == arpc_pkg::OP_FRAME) begin
          state_nxt = arpc_pkg::ST_REMOVE;
        end else if (item_r.op == arpc_pkg::OP_RESOLVE) begin
          state_nxt = arpc_pkg::ST_LOOKUP;
        end else begin
          state_nxt = arpc_pkg::ST_TICK;
        end
      end

      // close the gap left by an existing entry for the sender
      arpc_pkg::ST_REMOVE: begin
        ctl.shift_match = 1'b1;
        state_nxt       = arpc_pkg::ST_EVICT;
      end

      // make room when full
      arpc_pkg::ST_EVICT: begin
        ctl.shift_all = ent_valid[CACHE_DEPTH-1];
        state_nxt     = arpc_pkg::ST_APPEND;
      end

      // append at the tail and answer the frame
      arpc_pkg::ST_APPEND: begin
        ctl.load = 1'b1;
        emit     = 1'b1;
        if (item_r.target_ip != local_ip_r) begin
          res.status = arpc_pkg::STS_NOT_OURS;
        end else if (item_r.arp_opcode == arpc_pkg::ARP_OP_REQUEST) begin
          res.status           = arpc_pkg::STS_OK;
          res.send_frame       = 1'b1;
          res.frame_opcode     = arpc_pkg::FRM_OP_REPLY;
          res.frame_dest_mac   = item_r.sender_mac;
          res.frame_target_mac = item_r.sender_mac;
          res.frame_target_ip  = item_r.sender_ip;
        end else if (item_r.arp_opcode == arpc_pkg::ARP_OP_REPLY) begin
          if (waiting_r && (item_r.sender_ip == pending_ip_r)) begin
            waiting_nxt      = 1'b0;
            timer_nxt        = '0;
            tries_nxt        = '0;
            res.status       = arpc_pkg::STS_RESOLVED;
            res.resolve_done = 1'b1;
            res.resolve_ok   = 1'b1;
            res.resolved_mac = item_r.sender_mac;
          end else begin
            res.status = arpc_pkg::STS_UNASKED;
          end
        end else begin
          res.status = arpc_pkg::STS_OK;
        end
      end

      arpc_pkg::ST_LOOKUP: begin
        emit = 1'b1;
        if (hit) begin
          res.status       = arpc_pkg::STS_HIT;
          res.resolve_done = 1'b1;
          res.resolve_ok   = 1'b1;
          res.resolved_mac = hit_mac;
        end else if (waiting_r) begin
          res.status = arpc_pkg::STS_BUSY;
        end else begin
          pending_ip_nxt       = item_r.query_ip;
          waiting_nxt          = 1'b1;
          tries_nxt            = rcnt_eff - 4'd1;
          timer_nxt            = intv_eff;
          res.status           = arpc_pkg::STS_SENT;
          res.send_frame       = 1'b1;
          res.frame_opcode     = arpc_pkg::FRM_OP_REQUEST;
          res.frame_dest_mac   = arpc_pkg::MAC_BROADCAST;
          res.frame_target_mac = arpc_pkg::MAC_BROADCAST;
          res.frame_target_ip  = item_r.query_ip;
        end
      end

      // retry timer and retransmission
      arpc_pkg::ST_TICK: begin
        emit       = 1'b1;
        res.status = arpc_pkg::STS_OK;
        if (waiting_r) begin
          if (timer_r > 16'd1) begin
            timer_nxt = timer_r - 16'd1;
          end else if (tries_r != '0) begin
            tries_nxt            = tries_r - 4'd1;
            timer_nxt            = intv_eff;
            res.status           = arpc_pkg::STS_RETRY;
            res.send_frame       = 1'b1;
            res.frame_opcode     = arpc_pkg::FRM_OP_REQUEST;
            res.frame_dest_mac   = arpc_pkg::MAC_BROADCAST;
            res.frame_target_mac = arpc_pkg::MAC_BROADCAST;
            res.frame_target_ip  = pending_ip_r;
          end else begin
            waiting_nxt      = 1'b0;
            timer_nxt        = '0;
            res.status       = arpc_pkg::STS_FAILED;
            res.resolve_done = 1'b1;
          end
        end
      end

      default: state_nxt = arpc_pkg::ST_IDLE;
    endcase

    if (emit) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
      state_nxt     = arpc_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= arpc_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      now_r        <= '0;
      pending_ip_r <= '0;
      waiting_r    <= 1'b0;
      tries_r      <= '0;
      timer_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      now_r        <= now_nxt;
      pending_ip_r <= pending_ip_nxt;
      waiting_r    <= waiting_nxt;
      tries_r      <= tries_nxt;
      timer_r      <= timer_nxt;
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != arpc_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // checks
  `ARPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ARPC_ASSERT_NOW(a_strobe_idle, out_valid, !busy)
  `ARPC_ASSERT_NOW(a_chain_packed, 1'b1, ((ent_valid + CACHE_DEPTH'(1)) & ent_valid) == '0)
  `ARPC_ASSERT_NOW(a_ok_done, out_valid && out_result.resolve_ok, out_result.resolve_done)

endmodule
